@@ rtl/ppp_pkg.sv @@
// Shared constants, codes and width helpers of the perspective point projection core.
// Depends on nothing; every other file of the block uses it.
package ppp_pkg;

   localparam int COORD_BITS_DEF     = 16;
   localparam int TRIG_FRAC_BITS_DEF = 14;
   localparam int RADIUS_BITS        = 16;
   localparam int DIST_BITS          = 16;
   localparam int CSR_INDEX_BITS     = 3;

   // The queue depth must be a power of two so that its pointers wrap on their own.
   localparam int FIFO_DEPTH = 4;

   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(800);
   localparam logic [DIST_BITS-1:0]   DIST_RESET   = DIST_BITS'(1000);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SIN_THETA,
      CSR_COS_THETA,
      CSR_SIN_PHI,
      CSR_COS_PHI,
      CSR_VIEW_RADIUS,
      CSR_SCREEN_DISTANCE
   } csr_index_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // Width of the view coordinates, held at scale 2^(2*frac).
   function automatic int view_bits(input int coord_bits, input int trig_frac_bits);
      return 2 * (trig_frac_bits + 2) + max_int(coord_bits, RADIUS_BITS) + 2;
   endfunction

   // Width of the rounding numerator 2*d*v + zv.
   function automatic int num_bits(input int coord_bits, input int trig_frac_bits);
      return view_bits(coord_bits, trig_frac_bits) + DIST_BITS + 2;
   endfunction

   // Width of one queue entry: two numerators, the denominator and the depth flag.
   function automatic int entry_bits(input int coord_bits, input int trig_frac_bits);
      return 2 * num_bits(coord_bits, trig_frac_bits)
             + view_bits(coord_bits, trig_frac_bits) + 1;
   endfunction

endpackage

@@ rtl/ppp_if.sv @@
// Channel interfaces of the perspective point projection core: vertex requests and results.
// Depends on ppp_pkg for the default coordinate width.
interface ppp_req_if #(parameter int COORD_BITS = ppp_pkg::COORD_BITS_DEF) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic signed [COORD_BITS-1:0] point_z;

   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink (input valid, input point_x, input point_y, input point_z,
                 output ready);
endinterface

interface ppp_rsp_if #(parameter int COORD_BITS = ppp_pkg::COORD_BITS_DEF) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] screen_x;
   logic signed [COORD_BITS-1:0] screen_y;
   logic                         behind_eye;
   logic                         clipped;

   modport source (output valid, output screen_x, output screen_y, output behind_eye,
                   output clipped, input ready);
   modport sink (input valid, input screen_x, input screen_y, input behind_eye,
                 input clipped, output ready);
endinterface

@@ rtl/ppp_fifo.sv @@
// Short flip-flop queue between the front and the back of the projection core.
// Depends on ppp_pkg for the depth and the status struct.
module ppp_fifo #(
   parameter int DATA_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [DATA_BITS-1:0]        push_data,
   input  logic                        pop,
   output logic [DATA_BITS-1:0]        pop_data,
   output ppp_pkg::fifo_status_type    status
);
   import ppp_pkg::*;

   localparam int PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] DEPTH_COUNT = CNT_BITS'(FIFO_DEPTH);

   logic [DATA_BITS-1:0] mem_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;

   assign status.full  = (count_ff == DEPTH_COUNT);
   assign status.empty = (count_ff == '0);
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("Queue written while full.");

   a_pop_has_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("Queue read while empty.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_COUNT)
      else $error("Queue count beyond its depth.");

endmodule

@@ rtl/ppp_front.sv @@
// Front of the projection core: accepts vertices, rotates them into view coordinates,
// flags points behind the eye and forms the rounding numerators. Depends on ppp_pkg, ppp_if.
module ppp_front #(
   parameter int COORD_BITS     = ppp_pkg::COORD_BITS_DEF,
   parameter int TRIG_FRAC_BITS = ppp_pkg::TRIG_FRAC_BITS_DEF,
   localparam int TRIG_BITS     = TRIG_FRAC_BITS + 2,
   localparam int ENTRY_BITS    = ppp_pkg::entry_bits(COORD_BITS, TRIG_FRAC_BITS)
) (
   input  logic                              clock,
   input  logic                              reset,
   ppp_req_if.sink                           req_chan,
   input  logic signed [TRIG_BITS-1:0]       sin_theta,
   input  logic signed [TRIG_BITS-1:0]       cos_theta,
   input  logic signed [TRIG_BITS-1:0]       sin_phi,
   input  logic signed [TRIG_BITS-1:0]       cos_phi,
   input  logic [ppp_pkg::RADIUS_BITS-1:0]   view_radius,
   input  logic [ppp_pkg::DIST_BITS-1:0]     screen_distance,
   input  logic                              coef_wait,
   input  ppp_pkg::fifo_status_type          fifo_status,
   output logic                              push,
   output logic [ENTRY_BITS-1:0]             push_data
);
   import ppp_pkg::*;

   localparam int KW  = 2 * TRIG_BITS;
   localparam int PW  = TRIG_BITS + COORD_BITS;
   localparam int KPW = KW + COORD_BITS;
   localparam int VW  = view_bits(COORD_BITS, TRIG_FRAC_BITS);
   localparam int LO  = VW / 2;
   localparam int HI  = VW - LO;
   localparam int DLW = DIST_BITS + LO;
   localparam int DHW = DIST_BITS + 1 + HI;
   localparam int NW  = num_bits(COORD_BITS, TRIG_FRAC_BITS);

   logic advance, accept;

   logic signed [KW-1:0] k5_ff, k6_ff, k7_ff, k8_ff;

   logic                  s1_valid_ff;
   logic signed [PW-1:0]  p_cy_ff, p_sx_ff, p_spz_ff, p_cpz_ff;
   logic signed [KPW-1:0] p5x_ff, p6y_ff, p7x_ff, p8y_ff;

   logic                 s2_valid_ff;
   logic [VW-1:0]        rad_ext;
   logic signed [VW-1:0] rad_term;
   logic signed [VW-1:0] vx_in, vy_in, vz_in;
   logic signed [VW-1:0] vx_ff, vy_ff, vz_ff;

   logic                    s3_valid_ff;
   logic signed [HI-1:0]    vx_hi, vy_hi;
   logic signed [DIST_BITS:0] dist_s;
   logic                    behind_in;
   logic signed [DHW-1:0]   pxh_ff, pyh_ff;
   logic [DLW-1:0]          pxl_ff, pyl_ff;
   logic signed [VW-1:0]    vz3_ff;
   logic                    behind3_ff;

   logic                 s4_valid_ff;
   logic signed [NW-1:0] pxh_ext, pyh_ext, vz_ext;
   logic [NW-1:0]        pxl_ext, pyl_ext;
   logic signed [NW-1:0] num_x_in, num_y_in, num_x_ff, num_y_ff;
   logic [VW-1:0]        den_in, den_ff;
   logic                 behind4_ff;

   assign advance        = !fifo_status.full;
   assign accept         = req_chan.valid && advance && !coef_wait;
   assign req_chan.ready = advance && !coef_wait;

   // Second-order coefficients follow the angle registers.
   always_ff @(posedge clock) begin
      k5_ff <= KW'(cos_theta) * KW'(sin_phi);
      k6_ff <= KW'(sin_theta) * KW'(sin_phi);
      k7_ff <= KW'(cos_theta) * KW'(cos_phi);
      k8_ff <= KW'(sin_theta) * KW'(cos_phi);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_cy_ff  <= PW'(cos_theta) * PW'(req_chan.point_y);
         p_sx_ff  <= PW'(sin_theta) * PW'(req_chan.point_x);
         p_spz_ff <= PW'(sin_phi) * PW'(req_chan.point_z);
         p_cpz_ff <= PW'(cos_phi) * PW'(req_chan.point_z);
         p5x_ff   <= KPW'(k5_ff) * KPW'(req_chan.point_x);
         p6y_ff   <= KPW'(k6_ff) * KPW'(req_chan.point_y);
         p7x_ff   <= KPW'(k7_ff) * KPW'(req_chan.point_x);
         p8y_ff   <= KPW'(k8_ff) * KPW'(req_chan.point_y);
      end
   end

   assign rad_ext  = VW'(view_radius);
   assign rad_term = rad_ext << (2 * TRIG_FRAC_BITS);

   always_comb begin
      vx_in = (VW'(p_cy_ff) - VW'(p_sx_ff)) <<< TRIG_FRAC_BITS;
      vy_in = (VW'(p_spz_ff) <<< TRIG_FRAC_BITS) - VW'(p7x_ff) - VW'(p8y_ff);
      vz_in = rad_term - (VW'(p_cpz_ff) <<< TRIG_FRAC_BITS) - VW'(p5x_ff) - VW'(p6y_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         vz_ff <= vz_in;
      end
   end

   assign vx_hi     = vx_ff[VW-1:LO];
   assign vy_hi     = vy_ff[VW-1:LO];
   assign dist_s    = {1'b0, screen_distance};
   assign behind_in = vz_ff[VW-1] || (vz_ff == '0);

   // The distance product is split in two halves to keep each multiplier narrow.
   always_ff @(posedge clock) begin
      if (advance) begin
         pxh_ff     <= DHW'(dist_s) * DHW'(vx_hi);
         pyh_ff     <= DHW'(dist_s) * DHW'(vy_hi);
         pxl_ff     <= DLW'(screen_distance) * DLW'(vx_ff[LO-1:0]);
         pyl_ff     <= DLW'(screen_distance) * DLW'(vy_ff[LO-1:0]);
         vz3_ff     <= vz_ff;
         behind3_ff <= behind_in;
      end
   end

   assign pxh_ext = NW'(pxh_ff);
   assign pyh_ext = NW'(pyh_ff);
   assign pxl_ext = NW'(pxl_ff);
   assign pyl_ext = NW'(pyl_ff);
   assign vz_ext  = NW'(vz3_ff);

   always_comb begin
      num_x_in = (((pxh_ext << LO) + pxl_ext) << 1) + vz_ext;
      num_y_in = (((pyh_ext << LO) + pyl_ext) << 1) + vz_ext;
      den_in   = {vz3_ff[VW-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_x_ff   <= num_x_in;
         num_y_ff   <= num_y_in;
         den_ff     <= den_in;
         behind4_ff <= behind3_ff;
      end
   end

   assign push      = s4_valid_ff && advance;
   assign push_data = {num_x_ff, num_y_ff, den_ff, behind4_ff};

endmodule

@@ rtl/ppp_back.sv @@
// Back of the projection core: pipelined restoring divider, one quotient bit per stage,
// followed by saturation and the result register. Depends on ppp_pkg and ppp_if.
module ppp_back #(
   parameter int COORD_BITS     = ppp_pkg::COORD_BITS_DEF,
   parameter int TRIG_FRAC_BITS = ppp_pkg::TRIG_FRAC_BITS_DEF,
   localparam int ENTRY_BITS    = ppp_pkg::entry_bits(COORD_BITS, TRIG_FRAC_BITS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ppp_pkg::fifo_status_type   fifo_status,
   output logic                       pop,
   input  logic [ENTRY_BITS-1:0]      pop_data,
   ppp_rsp_if.source                  rsp_chan
);
   import ppp_pkg::*;

   localparam int CW  = COORD_BITS;
   localparam int VW  = view_bits(COORD_BITS, TRIG_FRAC_BITS);
   localparam int NW  = num_bits(COORD_BITS, TRIG_FRAC_BITS);
   localparam int EW  = NW + CW + 1;
   localparam int STG = CW + 2;
   localparam logic [CW:0] LIM = (CW + 1)'(1) << (CW - 1);
   localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW - 1){1'b1}}};
   localparam logic [CW-1:0] NEG_MIN = {1'b1, {(CW - 1){1'b0}}};

   logic advance;

   logic [NW-1:0] num_in [2];
   logic [VW-1:0] den_in;
   logic          behind_in;
   logic [NW-1:0] mag_in [2];

   logic          b0_valid_ff;
   logic [NW-1:0] b0_mag_ff [2];
   logic          b0_neg_ff [2];
   logic [VW-1:0] b0_den_ff;
   logic          b0_behind_ff;
   logic          ovf_in [2];

   logic [STG-1:0] valid_ff;
   logic [NW-1:0]  rem_ff [2][STG];
   logic [CW:0]    quo_ff [2][STG];
   logic           neg_ff [2][STG];
   logic           ovf_ff [2][STG];
   logic [VW-1:0]  den_ff [STG];
   logic           behind_ff [STG];

   logic [NW-1:0] rem_in [2][CW+1];
   logic [CW:0]   quo_in [2][CW+1];

   logic [CW-1:0] coord_in [2];
   logic          clip_in [2];

   logic          rsp_valid_ff;
   logic [CW-1:0] screen_x_ff, screen_y_ff;
   logic          behind_eye_ff, clipped_ff;

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign pop     = advance && !fifo_status.empty;

   assign num_in[0] = pop_data[ENTRY_BITS-1:VW+NW+1];
   assign num_in[1] = pop_data[VW+NW:VW+1];
   assign den_in    = pop_data[VW:1];
   assign behind_in = pop_data[0];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         mag_in[l] = num_in[l][NW-1] ? (~num_in[l] + 1'b1) : num_in[l];
         ovf_in[l] = EW'(b0_mag_ff[l]) >= (EW'(b0_den_ff) << (CW + 1));
      end
   end

   always_comb begin
      logic [EW-1:0] rem_ext;
      logic [EW-1:0] sub_ext;
      logic          take;
      for (int s = 0; s <= CW; s++) begin
         for (int l = 0; l < 2; l++) begin
            rem_ext = EW'(rem_ff[l][s]);
            sub_ext = EW'(den_ff[s]) << (CW - s);
            take    = rem_ext >= sub_ext;
            rem_in[l][s] = take ? NW'(rem_ext - sub_ext) : rem_ff[l][s];
            quo_in[l][s] = quo_ff[l][s];
            quo_in[l][s][CW - s] = take;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff  <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         b0_valid_ff  <= pop;
         valid_ff     <= {valid_ff[STG-2:0], b0_valid_ff};
         rsp_valid_ff <= valid_ff[STG-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b0_den_ff    <= den_in;
         b0_behind_ff <= behind_in;
         den_ff[0]    <= b0_den_ff;
         behind_ff[0] <= b0_behind_ff;
         for (int l = 0; l < 2; l++) begin
            b0_mag_ff[l] <= mag_in[l];
            b0_neg_ff[l] <= num_in[l][NW-1];
            rem_ff[l][0] <= b0_mag_ff[l];
            quo_ff[l][0] <= '0;
            neg_ff[l][0] <= b0_neg_ff[l];
            ovf_ff[l][0] <= ovf_in[l];
         end
         for (int s = 0; s <= CW; s++) begin
            den_ff[s + 1]    <= den_ff[s];
            behind_ff[s + 1] <= behind_ff[s];
            for (int l = 0; l < 2; l++) begin
               rem_ff[l][s + 1] <= rem_in[l][s];
               quo_ff[l][s + 1] <= quo_in[l][s];
               neg_ff[l][s + 1] <= neg_ff[l][s];
               ovf_ff[l][s + 1] <= ovf_ff[l][s];
            end
         end
      end
   end

   always_comb begin
      logic [CW:0] q;
      logic [CW:0] q_neg;
      for (int l = 0; l < 2; l++) begin
         q     = quo_ff[l][STG-1];
         q_neg = ~q + 1'b1;
         if (neg_ff[l][STG-1]) begin
            clip_in[l]  = ovf_ff[l][STG-1] || (q > LIM);
            coord_in[l] = clip_in[l] ? NEG_MIN : q_neg[CW-1:0];
         end else begin
            clip_in[l]  = ovf_ff[l][STG-1] || (q >= LIM);
            coord_in[l] = clip_in[l] ? POS_MAX : q[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (behind_ff[STG-1]) begin
            screen_x_ff <= '0;
            screen_y_ff <= '0;
            clipped_ff  <= 1'b0;
         end else begin
            screen_x_ff <= coord_in[0];
            screen_y_ff <= coord_in[1];
            clipped_ff  <= clip_in[0] || clip_in[1];
         end
         behind_eye_ff <= behind_ff[STG-1];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.screen_x   = screen_x_ff;
   assign rsp_chan.screen_y   = screen_y_ff;
   assign rsp_chan.behind_eye = behind_eye_ff;
   assign rsp_chan.clipped    = clipped_ff;

endmodule

@@ rtl/perspective_point_projection_core.sv @@
// Perspective point projection core, built on ppp_pkg, ppp_if, ppp_front, ppp_fifo and
// ppp_back. Each request transaction carries one 3-D vertex and yields exactly one response
// transaction with the projected screen coordinates, in order. The core takes one vertex per
// clock cycle for as long as the response side keeps up. The restoring divider in the back
// settles one quotient bit per pipeline stage. A four-entry queue separates the rotation
// front from the divider back, so requests keep flowing while a response is stalled, until
// the queue fills. Configuration registers are written through the csr_ port and must only
// change while the core holds no vertex. Requests are held off in the first cycle after
// reset and in the cycle after each configuration write, while the rotation coefficients
// follow the new angles.
module perspective_point_projection_core #(
   parameter int COORD_BITS     = ppp_pkg::COORD_BITS_DEF,
   parameter int TRIG_FRAC_BITS = ppp_pkg::TRIG_FRAC_BITS_DEF,
   localparam int CSR_DATA_BITS = ppp_pkg::max_int(TRIG_FRAC_BITS + 2, ppp_pkg::RADIUS_BITS)
) (
   input  logic                                clock,
   input  logic                                reset,
   ppp_req_if.sink                             req_chan,
   ppp_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [ppp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]            csr_wdata
);
   import ppp_pkg::*;

   localparam int TRIG_BITS  = TRIG_FRAC_BITS + 2;
   localparam int ENTRY_BITS = entry_bits(COORD_BITS, TRIG_FRAC_BITS);
   localparam logic signed [TRIG_BITS-1:0] TRIG_ONE = TRIG_BITS'(1) << TRIG_FRAC_BITS;

   logic signed [TRIG_BITS-1:0] sin_theta_ff, sin_theta_in;
   logic signed [TRIG_BITS-1:0] cos_theta_ff, cos_theta_in;
   logic signed [TRIG_BITS-1:0] sin_phi_ff, sin_phi_in;
   logic signed [TRIG_BITS-1:0] cos_phi_ff, cos_phi_in;
   logic [RADIUS_BITS-1:0]      view_radius_ff, view_radius_in;
   logic [DIST_BITS-1:0]        screen_distance_ff, screen_distance_in;
   logic                        coef_wait_ff, coef_wait_in;

   fifo_status_type        fifo_status;
   logic                   push, pop;
   logic [ENTRY_BITS-1:0]  push_data, pop_data;

   always_comb begin
      sin_theta_in       = sin_theta_ff;
      cos_theta_in       = cos_theta_ff;
      sin_phi_in         = sin_phi_ff;
      cos_phi_in         = cos_phi_ff;
      view_radius_in     = view_radius_ff;
      screen_distance_in = screen_distance_ff;
      coef_wait_in       = csr_we;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SIN_THETA:       sin_theta_in       = csr_wdata[TRIG_BITS-1:0];
            CSR_COS_THETA:       cos_theta_in       = csr_wdata[TRIG_BITS-1:0];
            CSR_SIN_PHI:         sin_phi_in         = csr_wdata[TRIG_BITS-1:0];
            CSR_COS_PHI:         cos_phi_in         = csr_wdata[TRIG_BITS-1:0];
            CSR_VIEW_RADIUS:     view_radius_in     = csr_wdata[RADIUS_BITS-1:0];
            CSR_SCREEN_DISTANCE: screen_distance_in = csr_wdata[DIST_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sin_theta_ff       <= -TRIG_ONE;
         cos_theta_ff       <= '0;
         sin_phi_ff         <= '0;
         cos_phi_ff         <= TRIG_ONE;
         view_radius_ff     <= RADIUS_RESET;
         screen_distance_ff <= DIST_RESET;
         coef_wait_ff       <= 1'b1;
      end else begin
         sin_theta_ff       <= sin_theta_in;
         cos_theta_ff       <= cos_theta_in;
         sin_phi_ff         <= sin_phi_in;
         cos_phi_ff         <= cos_phi_in;
         view_radius_ff     <= view_radius_in;
         screen_distance_ff <= screen_distance_in;
         coef_wait_ff       <= coef_wait_in;
      end
   end

   ppp_front #(
      .COORD_BITS     (COORD_BITS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .sin_theta       (sin_theta_ff),
      .cos_theta       (cos_theta_ff),
      .sin_phi         (sin_phi_ff),
      .cos_phi         (cos_phi_ff),
      .view_radius     (view_radius_ff),
      .screen_distance (screen_distance_ff),
      .coef_wait       (coef_wait_ff),
      .fifo_status     (fifo_status),
      .push            (push),
      .push_data       (push_data)
   );

   ppp_fifo #(
      .DATA_BITS (ENTRY_BITS)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (fifo_status)
   );

   ppp_back #(
      .COORD_BITS     (COORD_BITS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .pop         (pop),
      .pop_data    (pop_data),
      .rsp_chan    (rsp_chan)
   );

endmodule
